// ===== src/nqpt_pkg.sv =====
// shared constants, types and codes of the queue pair tracker
package nqpt_pkg;

  localparam int NUM_QUEUES  = 8;
  localparam int QUEUE_DEPTH = 64;
  localparam int TAG_W       = 16;

  localparam int QID_W       = $clog2(NUM_QUEUES);
  localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = SLOT_W + 1;
  localparam int TAG_ADDR_W  = QID_W + SLOT_W;
  localparam int TAG_DEPTH   = NUM_QUEUES * QUEUE_DEPTH;
  localparam int STRIDE_W    = 4;
  localparam int DB_W        = 21;
  localparam int SHIFT_W     = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;

  localparam logic [DB_W-1:0]       DB_BASE     = 21'h1000;
  localparam logic [CFG_DATA_W-1:0] ENTRIES_RST = 7'd64;

  // register indexes of the config port
  localparam logic [CFG_IDX_W-1:0] CFG_SQ_ENTRIES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CQ_ENTRIES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DB_STRIDE  = 2'd2;

  typedef enum logic {
    OP_SUBMIT   = 1'b0,
    OP_COMPLETE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_MOD,
    ST_FILL,
    ST_WB
  } state_t;

  // input beat, first field in the highest bits
  typedef struct packed {
    logic [SLOT_W-1:0] command_id;
    logic [SLOT_W-1:0] sq_head;
    logic [QID_W-1:0]  sq_id;
    logic              phase_bit;
    logic [TAG_W-1:0]  request_tag;
    logic [CNT_W-1:0]  entry_count;
    logic [QID_W-1:0]  queue_id;
  } in_item_t;

  // result beat, first field in the highest bits
  typedef struct packed {
    logic [CNT_W-1:0]  ring_load;
    logic [TAG_W-1:0]  completed_tag;
    logic              tag_valid;
    logic [SLOT_W-1:0] doorbell_value;
    logic [DB_W-1:0]   doorbell_offset;
    logic [SLOT_W-1:0] first_slot;
    logic              accepted;
  } res_t;

  localparam int IN_W       = $bits(in_item_t);
  localparam int RES_W      = $bits(res_t);
  localparam int S_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int M_TDATA_W  = ((RES_W + 7) / 8) * 8;

  // per submission ring record
  typedef struct packed {
    logic [CNT_W-1:0]  outstanding;
    logic [SLOT_W-1:0] head;
    logic [SLOT_W-1:0] tail;
  } sq_rec_t;

  // per completion ring record
  typedef struct packed {
    logic              phase;
    logic [SLOT_W-1:0] pos;
  } cq_rec_t;

  // slot tag word, valid bit on top
  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
  } tag_word_t;

  localparam int SQ_REC_W   = $bits(sq_rec_t);
  localparam int CQ_REC_W   = $bits(cq_rec_t);
  localparam int TAG_WORD_W = $bits(tag_word_t);

endpackage

// ===== src/nqpt_ram.sv =====
// generic simple dual port ram with registered read
module nqpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/nvme_queue_pair_tracker_core.sv =====
// top level of the nvme submission and completion queue pair tracker
//
//   channel  | signals                          | dir | content
//   ---------+----------------------------------+-----+---------------------------------
//   config   | cfg_we, cfg_index, cfg_wdata     | in  | sq_entries, cq_entries, stride
//   s (item) | s_tvalid, s_tready, s_tdata/user | in  | submit or completion observed
//   m (res)  | m_tvalid, m_tready, m_tdata      | out | one result beat per item
//
// one item at a time: accept, memory read, then writeback; an admitted submit adds
// a fill step (one slot tag written per cycle on the single tag ram write port),
// a completion whose stored sq head lies beyond a shrunken ring a modulo step
// (head reduced modulo the ring size one bit per cycle)
// after reset a clearing pass over all 512 tag ram addresses wipes the tag ram and ring records,
// s_tready stays low meanwhile; config writes are taken at any time
// a result waits in the output register; writeback stalls only while it is full
module nvme_queue_pair_tracker_core
  import nqpt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // queue_id, entry_count, request_tag, phase_bit, sq_id, sq_head, command_id
  input  logic [S_TDATA_W-1:0]  s_tdata,
  // opcode
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // accepted, first_slot, doorbell_offset, doorbell_value, tag_valid,
  // completed_tag, ring_load
  output logic [M_TDATA_W-1:0]  m_tdata
);

  // clamp a ring size register to the usable range
  function automatic logic [CNT_W-1:0] ring_size(logic [CFG_DATA_W-1:0] r);
    logic [CNT_W-1:0] s;
    s = CNT_W'(r);
    if (r < CFG_DATA_W'(2)) begin
      s = CNT_W'(2);
    end else if (r > CFG_DATA_W'(QUEUE_DEPTH)) begin
      s = CNT_W'(QUEUE_DEPTH);
    end
    return s;
  endfunction

  // config registers
  logic [CFG_DATA_W-1:0] sq_entries;
  logic [CFG_DATA_W-1:0] cq_entries;
  logic [STRIDE_W-1:0]   stride_exp;
  logic [CNT_W-1:0]      ssz;
  logic [CNT_W-1:0]      csz;

  // control
  state_t                state;
  state_t                state_next;
  logic [TAG_ADDR_W-1:0] clr_addr;
  logic                  s_fire;
  logic                  out_free;

  // item and captured records
  in_item_t              item;
  in_item_t              s_item;
  op_t                   op;
  sq_rec_t               sq_rec;
  tag_word_t             tag_word;
  logic [SLOT_W-1:0]     h_mod;
  logic [SLOT_W-1:0]     mod_src;
  logic                  admit;
  logic                  phase_ok;
  cq_rec_t               cq_new;
  logic [CNT_W-1:0]      fill_left;
  logic [SLOT_W-1:0]     fill_slot;

  // ram ports
  logic                  sq_we;
  logic [QID_W-1:0]      sq_waddr;
  sq_rec_t               sq_wdata;
  logic [QID_W-1:0]      sq_raddr;
  logic [SQ_REC_W-1:0]   sq_rdata;
  logic                  cq_we;
  cq_rec_t               cq_wdata;
  logic [CQ_REC_W-1:0]   cq_rdata;
  logic                  tag_we;
  logic [TAG_ADDR_W-1:0] tag_waddr;
  tag_word_t             tag_wdata;
  logic [TAG_WORD_W-1:0] tag_rdata;

  // exec stage values from the fresh ram data
  sq_rec_t               sq_rd;
  cq_rec_t               cq_rd;
  logic [CNT_W:0]        sub_sum;
  logic                  admit_next;
  logic [CNT_W-1:0]      pos_inc;
  cq_rec_t               cq_new_next;
  logic [CNT_W-1:0]      fill_inc;
  logic                  head_stale;
  logic [CNT_W-1:0]      mod_try;
  logic [SLOT_W-1:0]     h_mod_next;

  // writeback values
  logic [CNT_W:0]        used_sum;
  logic [CNT_W-1:0]      used;
  logic [CNT_W-1:0]      new_out;
  logic                  head_ok;
  logic [CNT_W-1:0]      sub_load;
  logic [QID_W:0]        db_index;
  logic [DB_W-1:0]       db_offset;
  logic                  slot_ok;
  res_t                  res;
  res_t                  res_next;

  assign ssz = ring_size(sq_entries);
  assign csz = ring_size(cq_entries);

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_entries <= ENTRIES_RST;
      cq_entries <= ENTRIES_RST;
      stride_exp <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SQ_ENTRIES: sq_entries <= cfg_wdata;
        CFG_CQ_ENTRIES: cq_entries <= cfg_wdata;
        CFG_DB_STRIDE:  stride_exp <= cfg_wdata[STRIDE_W-1:0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  assign s_item   = in_item_t'(s_tdata[IN_W-1:0]);
  assign s_tready = (state == ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // ---------------------------------------------------------------- memories
  // submission ring records: tail, head, outstanding load
  nqpt_ram #(.WIDTH(SQ_REC_W), .DEPTH(NUM_QUEUES)) u_sq_ram (
    .clk   (clk),
    .we    (sq_we),
    .waddr (sq_waddr),
    .wdata (sq_wdata),
    .raddr (sq_raddr),
    .rdata (sq_rdata)
  );

  // completion ring records: position and expected phase
  nqpt_ram #(.WIDTH(CQ_REC_W), .DEPTH(NUM_QUEUES)) u_cq_ram (
    .clk   (clk),
    .we    (cq_we),
    .waddr (state == ST_CLEAR ? clr_addr[QID_W-1:0] : item.queue_id),
    .wdata (cq_wdata),
    .raddr (s_item.queue_id),
    .rdata (cq_rdata)
  );

  // slot tags with their valid bit, addressed by ring and slot
  nqpt_ram #(.WIDTH(TAG_WORD_W), .DEPTH(TAG_DEPTH)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr ({s_item.sq_id, s_item.command_id}),
    .rdata (tag_rdata)
  );

  // submit reads the ring it fills, completion the ring named in the entry
  assign sq_raddr = (op_t'(s_tuser) == OP_SUBMIT) ? s_item.queue_id : s_item.sq_id;

  // ------------------------------------------------------------- exec stage
  always_comb begin
    sq_rd       = sq_rec_t'(sq_rdata);
    cq_rd       = cq_rec_t'(cq_rdata);
    sub_sum     = {1'b0, sq_rd.outstanding} + {1'b0, item.entry_count};
    admit_next  = (item.entry_count != '0) && (sub_sum <= {1'b0, ssz - CNT_W'(1)});
    pos_inc     = {1'b0, cq_rd.pos} + CNT_W'(1);
    cq_new_next = cq_rd;
    if (pos_inc >= csz) begin
      // wrap flips the expected phase
      cq_new_next.pos   = '0;
      cq_new_next.phase = !cq_rd.phase;
    end else begin
      cq_new_next.pos   = pos_inc[SLOT_W-1:0];
    end
    fill_inc = {1'b0, fill_slot} + CNT_W'(1);
    // a head left over from a larger ring needs reducing modulo the ring size
    head_stale = {1'b0, sq_rd.head} >= ssz;
    // one restoring remainder step per cycle, head bits taken msb first
    mod_try    = {h_mod, mod_src[SLOT_W-1]};
    h_mod_next = (mod_try >= ssz) ? SLOT_W'(mod_try - ssz) : mod_try[SLOT_W-1:0];
  end

  // -------------------------------------------------------- writeback stage
  always_comb begin
    head_ok  = {1'b0, item.sq_head} < ssz;
    used_sum = {2'b0, item.sq_head} + {1'b0, ssz} - {2'b0, h_mod};
    used     = (used_sum >= {1'b0, ssz}) ? CNT_W'(used_sum - {1'b0, ssz})
                                         : used_sum[CNT_W-1:0];
    // over-release saturates at zero
    new_out  = (used > sq_rec.outstanding) ? '0 : sq_rec.outstanding - used;
    sub_load = sq_rec.outstanding + item.entry_count;
    slot_ok  = {1'b0, item.command_id} < ssz;
    db_index = {item.queue_id, (op == OP_COMPLETE)};
    db_offset = DB_BASE + (DB_W'(db_index) << ({1'b0, stride_exp} + SHIFT_W'(2)));

    res_next = '0;
    if (op == OP_SUBMIT) begin
      res_next.ring_load = sq_rec.outstanding;
      if (admit) begin
        res_next.accepted        = 1'b1;
        res_next.first_slot      = sq_rec.tail;
        res_next.doorbell_offset = db_offset;
        res_next.doorbell_value  = fill_slot;
        res_next.ring_load       = sub_load;
      end
    end else begin
      res_next.ring_load = sq_rec.outstanding;
      if (phase_ok) begin
        res_next.accepted        = 1'b1;
        res_next.doorbell_offset = db_offset;
        res_next.doorbell_value  = cq_new.pos;
        res_next.ring_load       = head_ok ? new_out : sq_rec.outstanding;
        res_next.tag_valid       = slot_ok && tag_word.valid;
        res_next.completed_tag   = (slot_ok && tag_word.valid) ? tag_word.tag : '0;
      end
    end
  end

  // ram write selection
  always_comb begin
    sq_we     = 1'b0;
    sq_waddr  = item.queue_id;
    sq_wdata  = sq_rec;
    cq_we     = 1'b0;
    cq_wdata  = cq_new;
    tag_we    = 1'b0;
    tag_waddr = {item.queue_id, fill_slot};
    tag_wdata = '{valid: 1'b1, tag: item.request_tag};
    unique case (state)
      ST_CLEAR: begin
        sq_we     = 1'b1;
        sq_waddr  = clr_addr[QID_W-1:0];
        sq_wdata  = '0;
        cq_we     = 1'b1;
        cq_wdata  = '{phase: 1'b1, pos: '0};
        tag_we    = 1'b1;
        tag_waddr = clr_addr;
        tag_wdata = '0;
      end
      ST_FILL: begin
        tag_we = 1'b1;
      end
      ST_WB: begin
        if (out_free) begin
          if (op == OP_SUBMIT) begin
            sq_we    = admit;
            sq_wdata = '{outstanding: sub_load, head: sq_rec.head, tail: fill_slot};
          end else begin
            cq_we    = phase_ok;
            sq_we    = phase_ok && head_ok;
            sq_waddr = item.sq_id;
            sq_wdata = '{outstanding: new_out, head: item.sq_head, tail: sq_rec.tail};
          end
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_addr == '1) state_next = ST_IDLE;
      ST_IDLE:  if (s_fire) state_next = ST_EXEC;
      ST_EXEC: begin
        if (op == OP_SUBMIT && admit_next) begin
          state_next = ST_FILL;
        end else if (op == OP_COMPLETE && head_stale) begin
          state_next = ST_MOD;
        end else begin
          state_next = ST_WB;
        end
      end
      ST_MOD:   if (fill_left == CNT_W'(1)) state_next = ST_WB;
      ST_FILL:  if (fill_left == CNT_W'(1)) state_next = ST_WB;
      ST_WB:    if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + TAG_ADDR_W'(1);
    end
  end

  // item capture, exec results, slot walk and head reduction
  always_ff @(posedge clk) begin
    if (s_fire) begin
      item <= s_item;
      op   <= op_t'(s_tuser);
    end
    if (state == ST_EXEC) begin
      sq_rec    <= sq_rd;
      tag_word  <= tag_word_t'(tag_rdata);
      h_mod     <= head_stale ? '0 : sq_rd.head;
      mod_src   <= sq_rd.head;
      admit     <= admit_next;
      phase_ok  <= (item.phase_bit == cq_rd.phase);
      cq_new    <= cq_new_next;
      // slots to fill for a submit, remainder steps for a completion
      fill_left <= (op == OP_SUBMIT) ? item.entry_count : CNT_W'(SLOT_W);
      fill_slot <= sq_rd.tail;
    end else if (state == ST_MOD) begin
      h_mod     <= h_mod_next;
      mod_src   <= {mod_src[SLOT_W-2:0], 1'b0};
      fill_left <= fill_left - CNT_W'(1);
    end else if (state == ST_FILL) begin
      fill_left <= fill_left - CNT_W'(1);
      fill_slot <= (fill_inc >= ssz) ? '0 : fill_inc[SLOT_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_WB && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_WB && out_free) begin
      res <= res_next;
    end
  end

  assign m_tdata = {{(M_TDATA_W - RES_W){1'b0}}, res};

endmodule

// ===== src/nqpt_checker.sv =====
// port level checks of the queue pair tracker, bound to the top level
module nqpt_checker
  import nqpt_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_wdata,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [S_TDATA_W-1:0]  s_tdata,
  input logic                  s_tuser,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [M_TDATA_W-1:0]  m_tdata
);

  res_t r;
  assign r = res_t'(m_tdata[RES_W-1:0]);

  // clearing pass holds off input right after reset
  a_clear_blocks: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input ready right after reset");

  // one item in flight: no accept on the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready right after a beat");

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while stalled");

  // a rejected item reports no slot, doorbell or tag
  a_reject_quiet: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !r.accepted) |-> (r.first_slot == '0 && r.doorbell_offset == '0 &&
                                   r.doorbell_value == '0 && !r.tag_valid &&
                                   r.completed_tag == '0))
    else $error("rejected result carries data");

  // a tag is only reported by a consumed completion
  a_tag_needs_accept: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && r.tag_valid) |-> (r.accepted && r.first_slot == '0))
    else $error("tag reported without consumed completion");

endmodule

bind nvme_queue_pair_tracker_core nqpt_checker u_nqpt_checker (.*);
